// ----- rtl/wls_pkg.sv -----
package wls_pkg;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  replica_index;
    logic signed [15:0] weight_value;
    logic [30:0] view_number;
  } req_t;

  typedef struct packed {
    logic [3:0] leader_num;
    logic       weighted_used;
  } rsp_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;

  // divider start / done between sequencer and divider
  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// ----- rtl/wls_ram.sv -----
module wls_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/wls_div.sv -----
// Restoring divider: one quotient bit per cycle, remainder only.
module wls_div #(
  parameter int DW = 31,
  parameter int VW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [VW-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] num_q, num_d;
  logic [VW-1:0] dsr_q, dsr_d;
  logic [VW:0]   rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [VW:0]   trial;

  always_comb begin
    num_d  = num_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[VW-1:0], num_q[DW-1]};
    if (start_i) begin
      num_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[DW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[VW-1:0];

endmodule

// ----- rtl/weighted_leader_scheduler_unit.sv -----
// Weighted leader scheduler. Loads (opcode 0) store one clamped weight at the
// accepting edge and give no result, so loads can follow back to back. A query
// first scans the n active weights for the plain profile, then a 31-step
// restoring divider computes view mod n (plain rotation) or view mod schedule
// length (weighted); a weighted result is then read from the schedule memory.
// A plain query for view 0 answers right after the scan; a replica count of
// zero answers without a scan. The first weighted query after a weight load
// or a count or threshold write also rebuilds the schedule first: one or two
// weight sums, then one replica scan per slot, up to REPLICAS*WEIGHT_CAP slots,
// with the single credit adder/comparator shared across the scan. in_ready_o
// is low while a query is in work or its result waits.
module weighted_leader_scheduler_unit #(
  parameter int REPLICAS   = 8,
  parameter int WEIGHT_CAP = 100
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wls_pkg::req_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wls_pkg::rsp_t     out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int Depth = REPLICAS * WEIGHT_CAP;
  localparam int AW    = $clog2(Depth);
  localparam int LW    = $clog2(Depth + 1);
  localparam int RW    = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
  localparam int IW    = $clog2(REPLICAS + 1);
  localparam int WW    = $clog2(WEIGHT_CAP + 1);
  localparam int CRW   = LW + 2;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_SUM   = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_PICK  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_READ  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [3:0] cnt_q;
  logic [6:0] thr_q;
  logic       en_q;
  logic       stale_q, stale_d;
  logic [LW-1:0] len_q, len_d;
  logic [WW-1:0] wt_q [REPLICAS];
  logic signed [CRW-1:0] cr_q [REPLICAS];
  logic [30:0] view_q;
  logic [IW-1:0] ri_q, ri_d;
  logic [LW-1:0] step_q, step_d, tot_q, tot_d;
  logic [RW-1:0] best_q, best_d;
  logic found_q, found_d, plain_q, plain_d, allz_q, allz_d, wmode_q, wmode_d;
  logic signed [CRW-1:0] bestc_q, bestc_d;
  wls_pkg::rsp_t rsp_q, rsp_d;

  // config
  logic       wr;
  logic [1:0] ridx;
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign ridx   = paddr[3:2];

  always_comb begin
    prdata = '0;
    unique case (ridx)
      wls_pkg::REG_COUNT:  prdata = {28'd0, cnt_q};
      wls_pkg::REG_THRESH: prdata = {25'd0, thr_q};
      wls_pkg::REG_ENABLE: prdata = {31'd0, en_q};
      default:             prdata = '0;
    endcase
  end

  // effective parameters
  logic [IW-1:0] n;
  logic [6:0]    th;
  assign n  = ({1'b0, cnt_q} > 5'(REPLICAS)) ? IW'(REPLICAS) : IW'(cnt_q);
  assign th = (thr_q == 7'd0) ? 7'd1 : thr_q;

  // scan element (one replica per cycle)
  logic [RW-1:0] ri_r;
  logic [WW-1:0] w_cur;
  logic          ge_th;
  logic [WW-1:0] eff;
  logic signed [CRW-1:0] cr_new;
  assign ri_r  = ri_q[RW-1:0];
  assign w_cur = wt_q[ri_r];
  assign ge_th = {1'b0, w_cur} >= (WW+1)'(th);
  assign eff   = (allz_q || ge_th) ? w_cur : '0;
  assign cr_new = cr_q[ri_r] + $signed(CRW'(eff));

  // divider; the divisor is taken at the start edge, so follow the next mode
  logic          div_start, div_done;
  logic [LW-1:0] div_rem;
  logic [LW-1:0] div_dsr;
  assign div_dsr = wmode_d ? len_d : LW'(n);

  wls_div #(.DW(31), .VW(LW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(view_q),
    .divisor_i(div_dsr), .done_o(div_done), .rem_o(div_rem)
  );

  // schedule memory
  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [RW-1:0] ram_rd;
  assign ram_we = (state_q == S_PICK);
  assign ram_wa = step_q[AW-1:0];
  assign ram_ra = div_rem[AW-1:0];

  wls_ram #(.Width(RW), .Depth(Depth)) u_sched (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(best_q),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  logic cr_clear, cr_upd, cr_sub;
  logic load_fire;
  logic [WW-1:0] w_clamp;
  always_comb begin
    if (in_data_i.weight_value < 16'sd1) w_clamp = WW'(1);
    else if (in_data_i.weight_value > 16'(WEIGHT_CAP)) w_clamp = WW'(WEIGHT_CAP);
    else w_clamp = in_data_i.weight_value[WW-1:0];
  end

  always_comb begin
    state_d   = state_q;
    stale_d   = stale_q;
    len_d     = len_q;
    ri_d      = ri_q;
    step_d    = step_q;
    tot_d     = tot_q;
    best_d    = best_q;
    found_d   = found_q;
    bestc_d   = bestc_q;
    plain_d   = plain_q;
    allz_d    = allz_q;
    wmode_d   = wmode_q;
    rsp_d     = rsp_q;
    div_start = 1'b0;
    cr_clear  = 1'b0;
    cr_upd    = 1'b0;
    cr_sub    = 1'b0;
    load_fire = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.opcode == wls_pkg::OP_LOAD) begin
            load_fire = 1'b1;
          end else begin
            ri_d    = '0;
            plain_d = 1'b1;
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (n == '0) begin
          rsp_d   = '0;
          state_d = S_OUT;
        end else if (ri_q < n) begin
          if (w_cur != wt_q[0] || !ge_th) plain_d = 1'b0;
          ri_d = ri_q + IW'(1);
        end else if (!en_q || plain_q) begin
          wmode_d = 1'b0;
          if (view_q == '0) begin
            rsp_d   = '0;
            state_d = S_OUT;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end else if (stale_q) begin
          ri_d    = '0;
          tot_d   = '0;
          allz_d  = 1'b0;
          cr_clear = 1'b1;
          state_d = S_SUM;
        end else begin
          wmode_d   = 1'b1;
          div_start = (len_q != '0);
          if (len_q == '0) begin
            rsp_d = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_SUM: begin
        if (ri_q < n) begin
          tot_d = tot_q + LW'(eff);
          ri_d  = ri_q + IW'(1);
        end else if (tot_q == '0 && !allz_q) begin
          allz_d = 1'b1;
          ri_d   = '0;
        end else begin
          if (tot_q > LW'(Depth)) tot_d = LW'(Depth);
          step_d  = '0;
          ri_d    = '0;
          found_d = 1'b0;
          state_d = (tot_q == '0) ? S_DIV : S_SCAN;
          if (tot_q == '0) begin
            stale_d = 1'b0;
            len_d   = '0;
            wmode_d = 1'b1;
            rsp_d   = '0;
            state_d = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (ri_q < n) begin
          if (eff != '0) begin
            cr_upd = 1'b1;
            if (!found_q || cr_new > bestc_q) begin
              best_d  = ri_r;
              bestc_d = cr_new;
              found_d = 1'b1;
            end
          end
          ri_d = ri_q + IW'(1);
        end else begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        cr_sub  = 1'b1;
        ri_d    = '0;
        found_d = 1'b0;
        step_d  = step_q + LW'(1);
        if (step_q + LW'(1) == tot_q) begin
          len_d     = tot_q;
          stale_d   = 1'b0;
          wmode_d   = 1'b1;
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (wmode_q) begin
            state_d = S_READ;
          end else begin
            rsp_d   = '{leader_num: 4'(div_rem) + 4'd1, weighted_used: 1'b0};
            state_d = S_OUT;
          end
        end
      end
      S_READ: begin
        rsp_d   = '{leader_num: 4'(ram_rd) + 4'd1, weighted_used: 1'b1};
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (load_fire && (32'(in_data_i.replica_index) < REPLICAS)) stale_d = 1'b1;
    if (wr && (ridx == wls_pkg::REG_COUNT || ridx == wls_pkg::REG_THRESH)) begin
      stale_d = 1'b1;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= 4'd8;
      thr_q   <= 7'd1;
      en_q    <= 1'b0;
      stale_q <= 1'b1;
      len_q   <= '0;
      for (int i = 0; i < REPLICAS; i++) begin
        wt_q[i] <= WW'(1);
        cr_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      stale_q <= stale_d;
      len_q   <= len_d;
      if (wr) begin
        unique case (ridx)
          wls_pkg::REG_COUNT:  cnt_q <= pwdata[3:0];
          wls_pkg::REG_THRESH: thr_q <= pwdata[6:0];
          wls_pkg::REG_ENABLE: en_q  <= pwdata[0];
          default: ;
        endcase
      end
      if (load_fire && (32'(in_data_i.replica_index) < REPLICAS)) begin
        wt_q[RW'(in_data_i.replica_index)] <= w_clamp;
      end
      if (cr_clear) begin
        for (int i = 0; i < REPLICAS; i++) cr_q[i] <= '0;
      end else if (cr_upd) begin
        cr_q[ri_r] <= cr_new;
      end else if (cr_sub) begin
        cr_q[best_q] <= cr_q[best_q] - $signed({2'b0, tot_q});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) view_q <= in_data_i.view_number;
    ri_q    <= ri_d;
    step_q  <= step_d;
    tot_q   <= tot_d;
    best_q  <= best_d;
    found_q <= found_d;
    bestc_q <= bestc_d;
    plain_q <= plain_d;
    allz_q  <= allz_d;
    wmode_q <= wmode_d;
    rsp_q   <= rsp_d;
  end

endmodule

// ----- rtl/wls_checker.sv -----
module wls_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input wls_pkg::req_t in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input wls_pkg::rsp_t out_data_o
);

  // one request in work at a time
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_noqry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.opcode == wls_pkg::OP_LOAD |=> !out_valid_o)
    else $error("result after load");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped");

  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.weighted_used |-> out_data_o.leader_num != 4'd0)
    else $error("weighted leader zero");

endmodule

bind weighted_leader_scheduler_unit wls_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
  .out_valid_o, .out_ready_i, .out_data_o
);

// ----- tb/sv/weighted_leader_scheduler_unit_tb.sv -----
module weighted_leader_scheduler_unit_tb;

  localparam int REPLICAS   = 8;
  localparam int WEIGHT_CAP = 100;
  localparam int SLOTS      = REPLICAS * WEIGHT_CAP;
  localparam int STALL_LIMIT = 40000;
  localparam logic [3:0] ADDR_UNMAPPED = 4'd12;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  wls_pkg::req_t in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  wls_pkg::rsp_t out_data_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  weighted_leader_scheduler_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state
  logic [3:0]  cfg_count = 4'd8;
  logic [6:0]  cfg_thresh = 7'd1;
  logic        cfg_enable = 1'b0;
  logic [6:0]  weights [REPLICAS];
  logic [2:0]  schedule [SLOTS];
  int unsigned schedule_len = 0;
  bit          schedule_stale = 1'b1;

  wls_pkg::rsp_t expected_leaders [$];
  int   error_count = 0;
  int   queries_sent = 0;
  int   loads_sent = 0;
  int   leaders_checked = 0;
  int   weighted_seen = 0;
  bit   steady = 1'b0;  // no idling on either side

  initial forever #5 clk_i = ~clk_i;

  task automatic rebuild_schedule(int unsigned n, int unsigned th);
    int unsigned eff [REPLICAS];
    int          credit [REPLICAS];
    int unsigned total;
    int unsigned best;
    bit          found;
    total = 0;
    for (int i = 0; i < n; i++) begin
      eff[i] = (weights[i] >= th) ? weights[i] : 0;
      total += eff[i];
    end
    if (total == 0) begin
      for (int i = 0; i < n; i++) begin
        eff[i] = weights[i];
        total += eff[i];
      end
    end
    if (total > SLOTS) total = SLOTS;
    for (int i = 0; i < REPLICAS; i++) credit[i] = 0;
    for (int s = 0; s < total; s++) begin
      best = 0;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (eff[i] != 0) begin
          credit[i] += eff[i];
          if (!found || credit[i] > credit[best]) begin
            best = i;
            found = 1'b1;
          end
        end
      end
      schedule[s] = best[2:0];
      credit[best] -= total;
    end
    schedule_len = total;
    schedule_stale = 1'b0;
  endtask

  task automatic predict_request(wls_pkg::req_t r);
    int            w;
    int unsigned   n, th;
    bit            plain;
    wls_pkg::rsp_t res;
    if (r.opcode == wls_pkg::OP_LOAD) begin
      w = int'(r.weight_value);
      if (w < 1) w = 1;
      if (w > WEIGHT_CAP) w = WEIGHT_CAP;
      weights[r.replica_index] = w[6:0];
      schedule_stale = 1'b1;
      return;
    end
    res = '0;
    n = (cfg_count > REPLICAS) ? REPLICAS : cfg_count;
    th = (cfg_thresh < 1) ? 1 : cfg_thresh;
    if (n != 0) begin
      plain = 1'b1;
      for (int i = 0; i < n; i++)
        if (weights[i] != weights[0] || weights[i] < th) plain = 1'b0;
      if (cfg_enable && !plain) begin
        if (schedule_stale) rebuild_schedule(n, th);
        if (schedule_len != 0) begin
          res.leader_num = 4'(schedule[r.view_number % schedule_len]) + 4'd1;
          res.weighted_used = 1'b1;
        end
      end else if (r.view_number != 0) begin
        res.leader_num = 4'(r.view_number % n + 1);
      end
    end
    expected_leaders = {expected_leaders, res};
  endtask

  // send one request; valid stays high across back-to-back requests
  task automatic send_request(wls_pkg::req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(r);
    if (r.opcode == wls_pkg::OP_LOAD) loads_sent++;
    else queries_sent++;
  endtask

  task automatic send_load(logic [2:0] idx, logic [15:0] w);
    wls_pkg::req_t r;
    r = '0;
    r.opcode = wls_pkg::OP_LOAD;
    r.replica_index = idx;
    r.weight_value = w;
    r.view_number = 31'($urandom);
    send_request(r);
  endtask

  task automatic send_query(logic [30:0] view);
    wls_pkg::req_t r;
    r.opcode = wls_pkg::OP_QUERY;
    r.replica_index = 3'($urandom);
    r.weight_value = 16'($urandom);
    r.view_number = view;
    send_request(r);
  endtask

  // drain results, then idle a while before a register write
  task automatic drain_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_leaders.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (addr)
      {wls_pkg::REG_COUNT, 2'b00}: begin
        cfg_count = value[3:0];
        schedule_stale = 1'b1;
      end
      {wls_pkg::REG_THRESH, 2'b00}: begin
        cfg_thresh = value[6:0];
        schedule_stale = 1'b1;
      end
      {wls_pkg::REG_ENABLE, 2'b00}: cfg_enable = value[0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(logic [31:0] count, logic [31:0] th, logic [31:0] en);
    drain_idle();
    write_reg({wls_pkg::REG_COUNT, 2'b00}, count);
    write_reg({wls_pkg::REG_THRESH, 2'b00}, th);
    write_reg({wls_pkg::REG_ENABLE, 2'b00}, en);
  endtask

  // result checker with random receive stalls
  initial begin
    int            hold;
    wls_pkg::rsp_t want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_leaders.size() == 0) begin
          $error("unexpected result leader_num=%0d weighted_used=%0d",
                 out_data_o.leader_num, out_data_o.weighted_used);
          error_count++;
        end else begin
          want = expected_leaders[0];
          expected_leaders.delete(0);
          leaders_checked++;
          if (want.weighted_used) weighted_seen++;
          if (out_data_o.leader_num !== want.leader_num) begin
            $error("leader_num expected %0d got %0d", want.leader_num,
                   out_data_o.leader_num);
            error_count++;
          end
          if (out_data_o.weighted_used !== want.weighted_used) begin
            $error("weighted_used expected %0d got %0d",
                   want.weighted_used, out_data_o.weighted_used);
            error_count++;
          end
        end
        hold = steady ? 0 : $urandom_range(0, 4);
      end else if (hold > 0) begin
        hold--;
      end
      out_ready_i <= (hold == 0);
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic test_plain_rotation();
    send_query(31'd0);
    send_query(31'd1);
    send_query(31'd7);
    send_query(31'd8);
    send_query(31'h7fffffff);
  endtask

  task automatic test_weight_clamping();
    configure(32'd8, 32'd1, 32'd1);
    send_load(3'd0, 16'h8000);
    send_load(3'd1, 16'd0);
    send_load(3'd2, 16'd100);
    send_load(3'd3, 16'd101);
    send_load(3'd4, 16'h7fff);
    send_load(3'd5, 16'hffff);
    send_load(3'd6, 16'd2);
    send_load(3'd7, 16'd1);
    send_query(31'd0);
    send_query(31'd1);
    send_query(31'h7fffffff);
    send_query(31'd299);
  endtask

  task automatic test_register_edges();
    configure(32'hfffffff0, 32'd1, 32'd1);  // count zero: no leader
    send_query(31'd5);
    configure(32'd15, 32'd0, 32'd1);        // count saturates, threshold zero
    send_query(31'd9);
    configure(32'd8, 32'd127, 32'd1);       // all weights below threshold
    send_query(31'd3);
    drain_idle();
    write_reg(ADDR_UNMAPPED, 32'hffffffff);
    send_query(31'd4);
    configure(32'd1, 32'd100, 32'd0);
    send_query(31'd6);
  endtask

  task automatic test_random_phases();
    logic [31:0] settings [7][3];
    logic [15:0] w;
    settings = '{'{8, 1, 1}, '{5, 3, 1}, '{1, 1, 1}, '{15, 100, 1},
                 '{0, 1, 1}, '{3, 127, 1}, '{8, 1, 0}};
    for (int p = 0; p < 7; p++) begin
      configure(settings[p][0], settings[p][1], settings[p][2]);
      steady = (p == 2);
      // equal weights first so that plain rotation under weighted mode is hit
      if (p == 0) for (int i = 0; i < REPLICAS; i++) send_load(3'(i), 16'd4);
      for (int b = 0; b < 30; b++) begin
        repeat ($urandom_range(0, 4)) begin
          if ($urandom_range(0, 39) == 0) w = 16'($urandom);
          else w = 16'($urandom_range(0, 12));
          send_load(3'($urandom), w);
        end
        repeat ($urandom_range(3, 6)) begin
          if ($urandom_range(0, 9) == 0) send_query(31'($urandom_range(0, 20)));
          else send_query(31'($urandom));
        end
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < REPLICAS; i++) weights[i] = 7'd1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_rotation();
    test_weight_clamping();
    test_register_edges();
    test_random_phases();
    in_valid_i <= 1'b0;
    while (expected_leaders.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("sent %0d weight loads and %0d leader queries", loads_sent, queries_sent);
    $display("checked %0d leaders, %0d from the weighted schedule",
             leaders_checked, weighted_seen);
    if (error_count == 0 && expected_leaders.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/wls_pkg.sv
rtl/wls_ram.sv
rtl/wls_div.sv
rtl/weighted_leader_scheduler_unit.sv
rtl/wls_checker.sv
tb/sv/weighted_leader_scheduler_unit_tb.sv
